/* rtl/sorted_array_table_core_macros.svh */
// Assertion macros for the sorted array table core.
`ifndef SORTED_ARRAY_TABLE_CORE_MACROS_SVH
`define SORTED_ARRAY_TABLE_CORE_MACROS_SVH

// Same-cycle implication.
`define SAT_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sorted array table assertion failed");

// Next-cycle implication.
`define SAT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sorted array table assertion failed");

`endif

/* rtl/sat_pkg.sv */
// Package of the sorted array table: sizes, codes and shared types.
package sat_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int TOL_W       = 16;
  localparam int TYPE_W      = 3;
  localparam int STAT_W      = 3;
  localparam int RD_GRP      = 8;
  localparam int RD_NGRP     = (TABLE_DEPTH + RD_GRP - 1) / RD_GRP;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  typedef enum logic [TYPE_W-1:0] {
    OP_INSERT      = 3'd0,
    OP_FIND        = 3'd1,
    OP_REMOVE_AT   = 3'd2,
    OP_REMOVE_LAST = 3'd3,
    OP_READ        = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_RANGE     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_EMPTY     = 3'd4
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SEARCH,
    S_RD1,
    S_RD2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic flag_load;
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt_n;
    logic is_n;
    logic ge_idx;
  } cell_pos_t;

endpackage

/* rtl/sorted_array_table_core.sv */
// Sorted array table core: a chain of cells holding Q16.16 values in ascending order.
//
// Request channel (in_valid / in_stall): one word of req_type, item_value,
// item_index is taken when in_valid is high and in_stall low. One request is
// worked on at a time; in_stall stays high until its result is in the output
// register. Result channel (out_valid / out_stall): one word per request of
// status, result_index, result_value, entries_now, held while out_stall is high.
// The next request is taken while an earlier result still waits on out_stall.
// Tolerance write channel (cfg_valid / cfg_ready): cfg_ready is always high;
// write only between requests.
// Each request goes from accept to evaluate, then through the binary search
// (insert, find) and/or the cell read states RD1 and RD2 (read, remove-at,
// remove-last, find hit), then to the result load; error cases and unused codes
// go from evaluate straight to the load. The next request is taken in the cycle
// after a result is loaded. While out_stall holds a result, the next result waits
// in the block and in_stall stays high.
// The binary search steps one probe per cycle over the cell compare flags;
// cell reads go through a two-stage registered OR tree.
// Reset (rst, synchronous) empties the table, sets the tolerance to 66 and
// clears out_valid; cell contents are not cleared.
`include "sorted_array_table_core_macros.svh"

module sorted_array_table_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sat_pkg::TYPE_W-1:0]         req_type,
  input  logic signed [sat_pkg::VAL_W-1:0]   item_value,
  input  logic [sat_pkg::IDX_W-1:0]          item_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sat_pkg::STAT_W-1:0]         status,
  output logic [sat_pkg::IDX_W-1:0]          result_index,
  output logic signed [sat_pkg::VAL_W-1:0]   result_value,
  output logic [sat_pkg::CNT_W-1:0]          entries_now,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sat_pkg::TOL_W-1:0]          match_tolerance
);

  sat_pkg::state_t state, state_next;
  sat_pkg::op_t    op, op_next;
  sat_pkg::stat_t  stat, stat_next;
  sat_pkg::cell_ctrl_t ctrl;

  logic [sat_pkg::VAL_W-1:0] item, item_next;
  logic [sat_pkg::IDX_W-1:0] idx, idx_next;
  logic [sat_pkg::CNT_W-1:0] lo, lo_next, hi, hi_next;
  logic [sat_pkg::CNT_W-1:0] count, count_next;
  logic [sat_pkg::IDX_W-1:0] sel, sel_next;
  logic [sat_pkg::IDX_W-1:0] res_index, res_index_next;
  logic [sat_pkg::VAL_W-1:0] res_value, res_value_next;
  logic                      use_rd, use_rd_next;
  logic [sat_pkg::TOL_W-1:0] tolerance;
  logic                      rd_load;
  logic [sat_pkg::VAL_W-1:0] rd_value;

  logic                        out_valid_next;
  logic [sat_pkg::STAT_W-1:0]  status_next;
  logic [sat_pkg::IDX_W-1:0]   result_index_next;
  logic [sat_pkg::VAL_W-1:0]   result_value_next;
  logic [sat_pkg::CNT_W-1:0]   entries_now_next;

  logic [sat_pkg::CNT_W:0]   mid_sum;
  logic [sat_pkg::IDX_W-1:0] mid;
  logic                      out_free;
  logic                      out_err;

  logic [sat_pkg::TABLE_DEPTH-1:0][sat_pkg::VAL_W-1:0] cell_vals;
  logic [sat_pkg::TABLE_DEPTH-1:0] gt_vec, match_vec, after_vec, rd_sel;

  assign cfg_ready = 1'b1;
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[sat_pkg::IDX_W:1];
  assign out_free  = !out_valid || !out_stall;
  assign out_err   = out_valid && status != sat_pkg::STAT_OK;

  for (genvar i = 0; i < sat_pkg::TABLE_DEPTH; i++) begin : g_cell
    sat_pkg::cell_pos_t        pos;
    logic [sat_pkg::VAL_W-1:0] left_val;
    logic [sat_pkg::VAL_W-1:0] right_val;
    logic                      left_after;

    assign pos.lt_n   = i < int'(count);
    assign pos.is_n   = i == int'(count);
    assign pos.ge_idx = i >= int'(idx);
    assign rd_sel[i]  = i == int'(sel);

    if (i == 0) begin : g_first
      assign left_val   = '0;
      assign left_after = 1'b0;
    end else begin : g_mid
      assign left_val   = cell_vals[i-1];
      assign left_after = after_vec[i-1];
    end

    if (i == sat_pkg::TABLE_DEPTH - 1) begin : g_last
      assign right_val = cell_vals[i];
    end else begin : g_inner
      assign right_val = cell_vals[i+1];
    end

    sat_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos),
      .item       (item),
      .tol        (tolerance),
      .left_val   (left_val),
      .left_after (left_after),
      .right_val  (right_val),
      .cell_value (cell_vals[i]),
      .gt         (gt_vec[i]),
      .match      (match_vec[i]),
      .after      (after_vec[i])
    );
  end

  sat_readout u_readout (
    .clk       (clk),
    .cell_vals (cell_vals),
    .rd_sel    (rd_sel),
    .rd_load   (rd_load),
    .rd_value  (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sat_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      tolerance <= sat_pkg::TOL_RESET;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      if (cfg_valid) begin
        tolerance <= match_tolerance;
      end
    end
  end

  always_ff @(posedge clk) begin
    op           <= op_next;
    stat         <= stat_next;
    item         <= item_next;
    idx          <= idx_next;
    lo           <= lo_next;
    hi           <= hi_next;
    sel          <= sel_next;
    res_index    <= res_index_next;
    res_value    <= res_value_next;
    use_rd       <= use_rd_next;
    status       <= status_next;
    result_index <= result_index_next;
    result_value <= result_value_next;
    entries_now  <= entries_now_next;
  end

  always_comb begin
    state_next        = state;
    op_next           = op;
    stat_next         = stat;
    item_next         = item;
    idx_next          = idx;
    lo_next           = lo;
    hi_next           = hi;
    sel_next          = sel;
    res_index_next    = res_index;
    res_value_next    = res_value;
    use_rd_next       = use_rd;
    count_next        = count;
    ctrl              = '0;
    rd_load           = 1'b0;
    in_stall          = state != sat_pkg::S_IDLE;
    out_valid_next    = out_valid && out_stall;
    status_next       = status;
    result_index_next = result_index;
    result_value_next = result_value;
    entries_now_next  = entries_now;

    unique case (state)
      sat_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next    = sat_pkg::op_t'(req_type);
          item_next  = item_value;
          idx_next   = item_index;
          state_next = sat_pkg::S_EVAL;
        end
      end
      sat_pkg::S_EVAL: begin
        ctrl.flag_load = 1'b1;
        stat_next      = sat_pkg::STAT_OK;
        res_index_next = '0;
        res_value_next = '0;
        use_rd_next    = 1'b0;
        lo_next        = '0;
        hi_next        = count;
        state_next     = sat_pkg::S_DONE;
        unique case (op) inside
          sat_pkg::OP_INSERT: begin
            if (int'(count) == sat_pkg::TABLE_DEPTH) begin
              stat_next = sat_pkg::STAT_FULL;
            end else begin
              state_next = sat_pkg::S_SEARCH;
            end
          end
          sat_pkg::OP_FIND: begin
            state_next = sat_pkg::S_SEARCH;
          end
          sat_pkg::OP_REMOVE_AT, sat_pkg::OP_READ: begin
            if (sat_pkg::CNT_W'(idx) >= count) begin
              stat_next = sat_pkg::STAT_RANGE;
            end else begin
              sel_next       = idx;
              res_index_next = idx;
              use_rd_next    = 1'b1;
              state_next     = sat_pkg::S_RD1;
            end
          end
          sat_pkg::OP_REMOVE_LAST: begin
            if (count == '0) begin
              stat_next = sat_pkg::STAT_EMPTY;
            end else begin
              sel_next       = sat_pkg::IDX_W'(count - 1'b1);
              res_index_next = sat_pkg::IDX_W'(count - 1'b1);
              use_rd_next    = 1'b1;
              state_next     = sat_pkg::S_RD1;
            end
          end
          default: begin
            state_next = sat_pkg::S_DONE;
          end
        endcase
      end
      sat_pkg::S_SEARCH: begin
        if (lo < hi) begin
          if (op == sat_pkg::OP_FIND && match_vec[mid]) begin
            sel_next       = mid;
            res_index_next = mid;
            use_rd_next    = 1'b1;
            state_next     = sat_pkg::S_RD1;
          end else if (gt_vec[mid]) begin
            hi_next = sat_pkg::CNT_W'(mid);
          end else begin
            lo_next = sat_pkg::CNT_W'(mid) + 1'b1;
          end
        end else if (op == sat_pkg::OP_INSERT) begin
          ctrl.ins_en    = 1'b1;
          res_index_next = lo[sat_pkg::IDX_W-1:0];
          res_value_next = item;
          count_next     = count + 1'b1;
          state_next     = sat_pkg::S_DONE;
        end else begin
          stat_next  = sat_pkg::STAT_NOT_FOUND;
          state_next = sat_pkg::S_DONE;
        end
      end
      sat_pkg::S_RD1: begin
        state_next = sat_pkg::S_RD2;
      end
      sat_pkg::S_RD2: begin
        rd_load = 1'b1;
        if (op == sat_pkg::OP_REMOVE_AT) begin
          ctrl.del_en = 1'b1;
          count_next  = count - 1'b1;
        end else if (op == sat_pkg::OP_REMOVE_LAST) begin
          count_next = count - 1'b1;
        end
        state_next = sat_pkg::S_DONE;
      end
      sat_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          status_next       = stat;
          result_index_next = res_index;
          result_value_next = use_rd ? rd_value : res_value;
          entries_now_next  = count;
          state_next        = sat_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sat_pkg::S_IDLE;
      end
    endcase
  end

  `SAT_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, (int'(count) <= sat_pkg::TABLE_DEPTH))
  `SAT_ASSERT_IMPL(a_search_bounds, clk, rst, (state == sat_pkg::S_SEARCH), (lo <= hi))
  `SAT_ASSERT_NEXT(a_insert_count, clk, rst, ctrl.ins_en, (count == $past(count) + 1'b1))
  `SAT_ASSERT_IMPL(a_error_zero, clk, rst, out_err, (result_index == '0 && result_value == '0))

endmodule

/* rtl/sat_cell.sv */
// One table cell: holds an entry, its compare flags, and shifts to or from its neighbors.
module sat_cell (
  input  logic                          clk,
  input  sat_pkg::cell_ctrl_t           ctrl,
  input  sat_pkg::cell_pos_t            pos,
  input  logic [sat_pkg::VAL_W-1:0]     item,
  input  logic [sat_pkg::TOL_W-1:0]     tol,
  input  logic [sat_pkg::VAL_W-1:0]     left_val,
  input  logic                          left_after,
  input  logic [sat_pkg::VAL_W-1:0]     right_val,
  output logic [sat_pkg::VAL_W-1:0]     cell_value,
  output logic                          gt,
  output logic                          match,
  output logic                          after
);

  logic [sat_pkg::VAL_W:0] diff;
  logic [sat_pkg::VAL_W:0] abs_diff;
  logic                    gt_next;
  logic                    match_next;

  always_comb begin
    diff       = {cell_value[sat_pkg::VAL_W-1], cell_value} - {item[sat_pkg::VAL_W-1], item};
    abs_diff   = diff[sat_pkg::VAL_W] ? (~diff + 1'b1) : diff;
    gt_next    = $signed(cell_value) > $signed(item);
    match_next = abs_diff <= {{(sat_pkg::VAL_W + 1 - sat_pkg::TOL_W){1'b0}}, tol};
  end

  assign after = pos.lt_n & gt;

  always_ff @(posedge clk) begin
    if (ctrl.flag_load) begin
      gt    <= gt_next;
      match <= match_next;
    end
    if (ctrl.ins_en) begin
      if (left_after) begin
        cell_value <= left_val;
      end else if (after || pos.is_n) begin
        cell_value <= item;
      end
    end else if (ctrl.del_en && pos.ge_idx) begin
      cell_value <= right_val;
    end
  end

endmodule

/* rtl/sat_readout.sv */
// Two-stage registered OR tree that reads out the one selected cell.
module sat_readout (
  input  logic                                            clk,
  input  logic [sat_pkg::TABLE_DEPTH-1:0][sat_pkg::VAL_W-1:0] cell_vals,
  input  logic [sat_pkg::TABLE_DEPTH-1:0]                 rd_sel,
  input  logic                                            rd_load,
  output logic [sat_pkg::VAL_W-1:0]                       rd_value
);

  localparam int PAD = sat_pkg::RD_NGRP * sat_pkg::RD_GRP;

  logic [PAD-1:0][sat_pkg::VAL_W-1:0]              masked;
  logic [sat_pkg::RD_NGRP-1:0][sat_pkg::VAL_W-1:0] grp;
  logic [sat_pkg::RD_NGRP-1:0][sat_pkg::VAL_W-1:0] grp_next;
  logic [sat_pkg::VAL_W-1:0]                       rd_value_next;

  for (genvar i = 0; i < PAD; i++) begin : g_mask
    if (i < sat_pkg::TABLE_DEPTH) begin : g_live
      assign masked[i] = cell_vals[i] & {sat_pkg::VAL_W{rd_sel[i]}};
    end else begin : g_pad
      assign masked[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < sat_pkg::RD_NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < sat_pkg::RD_GRP; k++) begin
        grp_next[g] = grp_next[g] | masked[g * sat_pkg::RD_GRP + k];
      end
    end
    rd_value_next = '0;
    for (int g = 0; g < sat_pkg::RD_NGRP; g++) begin
      rd_value_next = rd_value_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_next;
    if (rd_load) begin
      rd_value <= rd_value_next;
    end
  end

endmodule
